// ----- src/spq_pkg.sv -----
// Shared types and codes for the sorted priority queue.
package spq_pkg;

   localparam int unsigned LEN_BITS    = 3;
   localparam int unsigned STATUS_BITS = 2;
   localparam int unsigned KIND_BITS   = 3;

   typedef enum logic [KIND_BITS-1:0] {
      REQ_INSERT  = 3'd0,
      REQ_EXTRACT = 3'd1,
      REQ_PEEK    = 3'd2,
      REQ_CHANGE  = 3'd3,
      REQ_DELETE  = 3'd4
   } req_kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      DP_HOLD,
      DP_PLACE,
      DP_REMOVE_MATCH,
      DP_REMOVE_HEAD
   } dp_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REINSERT
   } ctrl_state_type;

   typedef struct packed {
      logic       load_req;
      dp_op_type  op;
      logic       use_new_pri;
      logic       load_rsp;
      logic       take_head;
      status_type status;
   } dp_cmd_type;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic                 empty;
      logic                 full;
      logic                 found;
   } dp_status_type;

endpackage

// ----- src/spq_ctrl.sv -----
// Request sequencer: steps each request through its removal and placement cycles.
module spq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_accept,
   input  logic                   rsp_tready,
   input  spq_pkg::dp_status_type dp_status,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   output spq_pkg::dp_cmd_type    dp_cmd
);

   spq_pkg::ctrl_state_type state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in           = state_ff;
      req_tready         = 1'b0;
      dp_cmd.load_req    = 1'b0;
      dp_cmd.op          = spq_pkg::DP_HOLD;
      dp_cmd.use_new_pri = 1'b0;
      dp_cmd.load_rsp    = 1'b0;
      dp_cmd.take_head   = 1'b0;
      dp_cmd.status      = spq_pkg::STATUS_MISS;
      case (state_ff)
         spq_pkg::ST_IDLE: begin
            req_tready      = 1'b1;
            dp_cmd.load_req = req_accept;
            if (req_accept) begin
               state_in = spq_pkg::ST_EXEC;
            end
         end
         spq_pkg::ST_EXEC: begin
            // hold the whole operation until the result register can take it
            if (out_free) begin
               state_in        = spq_pkg::ST_IDLE;
               dp_cmd.load_rsp = 1'b1;
               case (dp_status.kind)
                  spq_pkg::REQ_INSERT: begin
                     if (dp_status.full) begin
                        dp_cmd.status = spq_pkg::STATUS_FULL;
                     end else begin
                        dp_cmd.op     = spq_pkg::DP_PLACE;
                        dp_cmd.status = spq_pkg::STATUS_OK;
                     end
                  end
                  spq_pkg::REQ_EXTRACT: begin
                     if (!dp_status.empty) begin
                        dp_cmd.op        = spq_pkg::DP_REMOVE_HEAD;
                        dp_cmd.take_head = 1'b1;
                        dp_cmd.status    = spq_pkg::STATUS_OK;
                     end
                  end
                  spq_pkg::REQ_PEEK: begin
                     if (!dp_status.empty) begin
                        dp_cmd.take_head = 1'b1;
                        dp_cmd.status    = spq_pkg::STATUS_OK;
                     end
                  end
                  spq_pkg::REQ_DELETE: begin
                     if (dp_status.found) begin
                        dp_cmd.op     = spq_pkg::DP_REMOVE_MATCH;
                        dp_cmd.status = spq_pkg::STATUS_OK;
                     end
                  end
                  spq_pkg::REQ_CHANGE: begin
                     if (dp_status.found) begin
                        // remove now, report after the reinsertion
                        dp_cmd.op       = spq_pkg::DP_REMOVE_MATCH;
                        dp_cmd.load_rsp = 1'b0;
                        state_in        = spq_pkg::ST_REINSERT;
                     end
                  end
                  default: begin
                     dp_cmd.status = spq_pkg::STATUS_MISS;
                  end
               endcase
            end
         end
         spq_pkg::ST_REINSERT: begin
            if (out_free) begin
               dp_cmd.op          = spq_pkg::DP_PLACE;
               dp_cmd.use_new_pri = 1'b1;
               dp_cmd.load_rsp    = 1'b1;
               dp_cmd.status      = spq_pkg::STATUS_OK;
               state_in           = spq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spq_pkg::ST_IDLE;
         end
      endcase
      rsp_valid_in = dp_cmd.load_rsp || (rsp_valid_ff && !rsp_tready);
   end

endmodule

// ----- src/spq_datapath.sv -----
// Sorted shifting entry array with parallel compare, request and result registers.
module spq_datapath #(
   parameter int unsigned QUEUE_DEPTH   = 16,
   parameter int unsigned PRIORITY_BITS = 16,
   parameter int unsigned PAYLOAD_BYTES = 4,
   localparam int unsigned PW = PAYLOAD_BYTES * 8,
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  spq_pkg::dp_cmd_type              dp_cmd,
   output spq_pkg::dp_status_type           dp_status,
   input  logic [spq_pkg::KIND_BITS-1:0]    req_kind,
   input  logic signed [PRIORITY_BITS-1:0]  req_priority,
   input  logic [PW-1:0]                    req_payload,
   input  logic [spq_pkg::LEN_BITS-1:0]     req_len,
   input  logic signed [PRIORITY_BITS-1:0]  req_new_priority,
   output logic [spq_pkg::STATUS_BITS-1:0]  rsp_status,
   output logic signed [PRIORITY_BITS-1:0]  rsp_priority,
   output logic [PW-1:0]                    rsp_payload,
   output logic [spq_pkg::LEN_BITS-1:0]     rsp_len,
   output logic [CW-1:0]                    rsp_occupancy
);

   localparam int unsigned LB = spq_pkg::LEN_BITS;

   // request register
   logic [spq_pkg::KIND_BITS-1:0]   kind_ff;
   logic signed [PRIORITY_BITS-1:0] pri_ff, new_pri_ff;
   logic [PW-1:0]                   pay_ff, pay_in;
   logic [LB-1:0]                   len_ff, len_in;

   // entry array, entries at and above count are unused
   logic signed [PRIORITY_BITS-1:0] epri_ff [QUEUE_DEPTH];
   logic signed [PRIORITY_BITS-1:0] epri_in [QUEUE_DEPTH];
   logic [PW-1:0]                   epay_ff [QUEUE_DEPTH];
   logic [PW-1:0]                   epay_in [QUEUE_DEPTH];
   logic [LB-1:0]                   elen_ff [QUEUE_DEPTH];
   logic [LB-1:0]                   elen_in [QUEUE_DEPTH];
   logic [CW-1:0]                   count_ff, count_in;

   // result register
   logic [spq_pkg::STATUS_BITS-1:0] ostat_ff;
   logic signed [PRIORITY_BITS-1:0] opri_ff;
   logic [PW-1:0]                   opay_ff;
   logic [LB-1:0]                   olen_ff;
   logic [CW-1:0]                   occ_ff;

   logic signed [PRIORITY_BITS-1:0] key;
   logic [QUEUE_DEPTH-1:0]          keep, match, hit_upto;

   // clamp the length and clear bytes beyond it
   always_comb begin
      if ({1'b0, req_len} > (LB + 1)'(PAYLOAD_BYTES)) begin
         len_in = LB'(PAYLOAD_BYTES);
      end else begin
         len_in = req_len;
      end
      for (int b = 0; b < PAYLOAD_BYTES; b++) begin
         pay_in[b*8 +: 8] = ((LB + 1)'(b) < {1'b0, len_in}) ? req_payload[b*8 +: 8] : 8'd0;
      end
   end

   assign key = dp_cmd.use_new_pri ? new_pri_ff : pri_ff;

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         keep[i]  = (CW'(i) < count_ff) && (epri_ff[i] >= key);
         match[i] = (CW'(i) < count_ff) && (epri_ff[i] == pri_ff) &&
                    (epay_ff[i] == pay_ff) && (elen_ff[i] == len_ff);
      end
      hit_upto[0] = match[0] || (dp_cmd.op == spq_pkg::DP_REMOVE_HEAD);
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
         hit_upto[i] = hit_upto[i-1] || match[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         epri_in[i] = epri_ff[i];
         epay_in[i] = epay_ff[i];
         elen_in[i] = elen_ff[i];
      end
      case (dp_cmd.op)
         spq_pkg::DP_PLACE: begin
            // keep the prefix of greater or equal priority, open a gap behind it
            count_in = count_ff + CW'(1);
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
               if (!keep[i]) begin
                  if (i == 0 || keep[(i == 0) ? 0 : i-1]) begin
                     epri_in[i] = key;
                     epay_in[i] = pay_ff;
                     elen_in[i] = len_ff;
                  end else begin
                     epri_in[i] = epri_ff[(i == 0) ? 0 : i-1];
                     epay_in[i] = epay_ff[(i == 0) ? 0 : i-1];
                     elen_in[i] = elen_ff[(i == 0) ? 0 : i-1];
                  end
               end
            end
         end
         spq_pkg::DP_REMOVE_MATCH, spq_pkg::DP_REMOVE_HEAD: begin
            // close the gap from the removed entry onward
            count_in = count_ff - CW'(1);
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
               if (hit_upto[i]) begin
                  epri_in[i] = epri_ff[i+1];
                  epay_in[i] = epay_ff[i+1];
                  elen_in[i] = elen_ff[i+1];
               end
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         epri_ff[i] <= epri_in[i];
         epay_ff[i] <= epay_in[i];
         elen_ff[i] <= elen_in[i];
      end
      if (dp_cmd.load_req) begin
         kind_ff    <= req_kind;
         pri_ff     <= req_priority;
         new_pri_ff <= req_new_priority;
         pay_ff     <= pay_in;
         len_ff     <= len_in;
      end
      if (dp_cmd.load_rsp) begin
         ostat_ff <= dp_cmd.status;
         occ_ff   <= count_in;
         opri_ff  <= dp_cmd.take_head ? epri_ff[0] : '0;
         opay_ff  <= dp_cmd.take_head ? epay_ff[0] : '0;
         olen_ff  <= dp_cmd.take_head ? elen_ff[0] : '0;
      end
   end

   assign dp_status.kind  = kind_ff;
   assign dp_status.empty = (count_ff == '0);
   assign dp_status.full  = (count_ff == CW'(QUEUE_DEPTH));
   assign dp_status.found = |match;

   assign rsp_status    = ostat_ff;
   assign rsp_priority  = opri_ff;
   assign rsp_payload   = opay_ff;
   assign rsp_len       = olen_ff;
   assign rsp_occupancy = occ_ff;

endmodule

// ----- src/sorted_priority_queue.sv -----
// Sorted priority queue: top level with stream ports.
//
// A bounded priority queue of QUEUE_DEPTH entries held as a list sorted by
// descending priority, first in first out among equal priorities. Each request
// (insert, extract max, peek max, change priority, delete) gives exactly one
// result with a status (0 ok, 1 empty or not found, 2 full), the head entry for
// a successful extract or peek (zero otherwise) and the occupancy after the
// request. Lengths above PAYLOAD_BYTES saturate and payload bytes at or above
// the length are cleared before storing or matching. A request is first
// registered, then passes through the parallel compare and shift of the
// sorted entry array; change priority needs a pass of that array for the
// removal and another for the reinsertion. The result register waits for
// rsp_tready, and a new request is taken while a result still waits.
module sorted_priority_queue #(
   parameter int unsigned QUEUE_DEPTH   = 16,
   parameter int unsigned PRIORITY_BITS = 16,
   parameter int unsigned PAYLOAD_BYTES = 4,
   localparam int unsigned PW  = PAYLOAD_BYTES * 8,
   localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1),
   localparam int unsigned RQW = ((2 * PRIORITY_BITS + PW + spq_pkg::LEN_BITS) + 7) / 8 * 8,
   localparam int unsigned RSW = ((PRIORITY_BITS + PW + spq_pkg::LEN_BITS + CW) + 7) / 8 * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // priority_req, payload, payload_len, new_priority, zero fill
   input  logic [RQW-1:0]                    req_tdata,
   // req_type
   input  logic [spq_pkg::KIND_BITS-1:0]     req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_priority, out_payload, out_len, occupancy, zero fill
   output logic [RSW-1:0]                    rsp_tdata,
   // status
   output logic [spq_pkg::STATUS_BITS-1:0]   rsp_tuser
);

   localparam int unsigned LB      = spq_pkg::LEN_BITS;
   localparam int unsigned PAY_LO  = PRIORITY_BITS;
   localparam int unsigned LEN_LO  = PAY_LO + PW;
   localparam int unsigned NPRI_LO = LEN_LO + LB;

   spq_pkg::dp_cmd_type             dp_cmd;
   spq_pkg::dp_status_type          dp_status;
   logic signed [PRIORITY_BITS-1:0] out_priority;
   logic [PW-1:0]                   out_payload;
   logic [LB-1:0]                   out_len;
   logic [CW-1:0]                   occupancy;

   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_tvalid && req_tready),
      .rsp_tready (rsp_tready),
      .dp_status  (dp_status),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .dp_cmd     (dp_cmd)
   );

   spq_datapath #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .PRIORITY_BITS (PRIORITY_BITS),
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status),
      .req_kind         (req_tuser),
      .req_priority     (req_tdata[PRIORITY_BITS-1:0]),
      .req_payload      (req_tdata[PAY_LO +: PW]),
      .req_len          (req_tdata[LEN_LO +: LB]),
      .req_new_priority (req_tdata[NPRI_LO +: PRIORITY_BITS]),
      .rsp_status       (rsp_tuser),
      .rsp_priority     (out_priority),
      .rsp_payload      (out_payload),
      .rsp_len          (out_len),
      .rsp_occupancy    (occupancy)
   );

   assign rsp_tdata = RSW'({occupancy, out_len, out_payload, out_priority});

endmodule

// ----- sim/testbench.sv -----
// Self-checking stream testbench for the sorted priority queue.
`timescale 1ns / 1ps

module testbench;

   localparam int QUEUE_DEPTH   = 16;
   localparam int PRIORITY_BITS = 16;
   localparam int PAYLOAD_BYTES = 4;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int REPORT_CAP    = 100;
   localparam logic [spq_pkg::KIND_BITS-1:0] REQ_UNUSED_LO = 3'd5;
   localparam logic [spq_pkg::KIND_BITS-1:0] KIND_MAX      = 3'd7;

   typedef struct packed {
      spq_pkg::status_type status;
      logic signed [15:0]  pri;
      logic [31:0]         pay;
      logic [2:0]          len;
      logic [4:0]          occupancy;
   } queue_result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   // shadow copy of the sorted entry list
   logic signed [15:0] held_pri [QUEUE_DEPTH];
   logic [31:0]        held_pay [QUEUE_DEPTH];
   logic [2:0]         held_len [QUEUE_DEPTH];
   int                 held_count;

   queue_result_type expected_results[$];

   int  error_count;
   int  cycle_count;
   int  kind_count [8];
   int  full_count;
   int  miss_count;
   int  peak_occupancy;
   bit  sender_idle;
   bit  receiver_idle;
   int  stall_left;

   sorted_priority_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .PRIORITY_BITS(PRIORITY_BITS),
      .PAYLOAD_BYTES(PAYLOAD_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      // priority_req, payload, payload_len, new_priority, zero fill
      .req_tdata(req_tdata),
      // req_type
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      // out_priority, out_payload, out_len, occupancy, zero fill
      .rsp_tdata(rsp_tdata),
      // status
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("testbench: errors");
         $finish;
      end
   end

   function automatic logic [31:0] len_mask(input logic [2:0] len);
      if (len >= PAYLOAD_BYTES)
         return '1;
      return (32'd1 << (8 * len)) - 32'd1;
   endfunction

   function automatic logic signed [15:0] rand_priority();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(0, 6)) - 3);
         2: begin
            case ($urandom_range(0, 3))
               0: return 16'sh8000;
               1: return 16'sh7FFF;
               2: return -16'sd1;
               default: return 16'sd0;
            endcase
         end
         default: return 16'($signed($urandom_range(0, 15)) - 8);
      endcase
   endfunction

   function automatic logic [31:0] rand_payload();
      case ($urandom_range(0, 3))
         0, 1: return $urandom;
         2: return 32'($urandom_range(0, 3));
         default: return '1;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= REPORT_CAP)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic place_entry(input logic signed [15:0] pri, input logic [31:0] pay,
                              input logic [2:0] len);
      int pos = 0;
      while (pos < held_count && held_pri[pos] >= pri)
         pos++;
      for (int i = held_count; i > pos; i--) begin
         held_pri[i] = held_pri[i-1];
         held_pay[i] = held_pay[i-1];
         held_len[i] = held_len[i-1];
      end
      held_pri[pos] = pri;
      held_pay[pos] = pay;
      held_len[pos] = len;
      held_count++;
   endtask

   task automatic remove_entry(input int pos);
      for (int i = pos; i + 1 < held_count; i++) begin
         held_pri[i] = held_pri[i+1];
         held_pay[i] = held_pay[i+1];
         held_len[i] = held_len[i+1];
      end
      held_count--;
   endtask

   // Apply one request to the shadow list and work out its result.
   task automatic predict_queue_result(input logic [2:0] kind,
                                       input logic signed [15:0] pri,
                                       input logic [31:0] pay_raw,
                                       input logic [2:0] len_raw,
                                       input logic signed [15:0] npri,
                                       output queue_result_type res);
      logic [2:0]  len;
      logic [31:0] pay;
      int          pos;
      len = (len_raw > PAYLOAD_BYTES) ? 3'(PAYLOAD_BYTES) : len_raw;
      pay = pay_raw & len_mask(len);
      res = '0;
      res.status = spq_pkg::STATUS_MISS;
      case (kind)
         spq_pkg::REQ_INSERT: begin
            if (held_count >= QUEUE_DEPTH) begin
               res.status = spq_pkg::STATUS_FULL;
            end else begin
               place_entry(pri, pay, len);
               res.status = spq_pkg::STATUS_OK;
            end
         end
         spq_pkg::REQ_EXTRACT, spq_pkg::REQ_PEEK: begin
            if (held_count > 0) begin
               res.pri = held_pri[0];
               res.pay = held_pay[0];
               res.len = held_len[0];
               if (kind == spq_pkg::REQ_EXTRACT)
                  remove_entry(0);
               res.status = spq_pkg::STATUS_OK;
            end
         end
         spq_pkg::REQ_CHANGE, spq_pkg::REQ_DELETE: begin
            pos = -1;
            for (int i = 0; i < held_count && pos < 0; i++)
               if (held_pri[i] == pri && held_len[i] == len && held_pay[i] == pay)
                  pos = i;
            if (pos >= 0) begin
               remove_entry(pos);
               if (kind == spq_pkg::REQ_CHANGE)
                  place_entry(npri, pay, len);
               res.status = spq_pkg::STATUS_OK;
            end
         end
         default: ;
      endcase
      res.occupancy = 5'(held_count);
   endtask

   // Present one request and hold it until the transfer happens.
   task automatic send_request(input logic [2:0] kind, input logic signed [15:0] pri,
                               input logic [31:0] pay, input logic [2:0] len,
                               input logic signed [15:0] npri);
      queue_result_type res;
      int               gap;
      if (sender_idle && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 12);
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = {5'b0, npri, len, pay, pri};
      do @(posedge clock); while (!req_tready);
      predict_queue_result(kind, pri, pay, len, npri, res);
      expected_results.push_back(res);
      kind_count[kind]++;
      if (res.status == spq_pkg::STATUS_FULL)
         full_count++;
      if (res.status == spq_pkg::STATUS_MISS)
         miss_count++;
      if (held_count > peak_occupancy)
         peak_occupancy = held_count;
   endtask

   // Hold off the sender until every outstanding result has arrived.
   task automatic drain_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic random_request(input int insert_weight);
      logic [2:0]         kind;
      logic signed [15:0] pri;
      logic signed [15:0] npri;
      logic [31:0]        pay;
      logic [2:0]         len;
      int                 pick;
      pri  = rand_priority();
      npri = rand_priority();
      pay  = rand_payload();
      len  = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 99) < insert_weight) begin
         kind = spq_pkg::REQ_INSERT;
      end else begin
         pick = $urandom_range(0, 19);
         if (pick <= 5)
            kind = spq_pkg::REQ_EXTRACT;
         else if (pick <= 8)
            kind = spq_pkg::REQ_PEEK;
         else if (pick <= 13)
            kind = spq_pkg::REQ_CHANGE;
         else if (pick <= 18)
            kind = spq_pkg::REQ_DELETE;
         else
            kind = 3'($urandom_range(REQ_UNUSED_LO, KIND_MAX));
      end
      // aim most lookups at a held entry, with junk above its length
      if ((kind == spq_pkg::REQ_CHANGE || kind == spq_pkg::REQ_DELETE) && held_count > 0 &&
          $urandom_range(0, 4) != 0) begin
         pick = $urandom_range(0, held_count - 1);
         pri  = held_pri[pick];
         len  = held_len[pick];
         pay  = held_pay[pick] | (rand_payload() & ~len_mask(held_len[pick]));
         if (len == PAYLOAD_BYTES && $urandom_range(0, 1) == 1)
            len = 3'($urandom_range(PAYLOAD_BYTES, 7));
      end
      send_request(kind, pri, pay, len, npri);
   endtask

   always @(negedge clock) begin
      if (receiver_idle && stall_left == 0 && $urandom_range(0, 6) == 0)
         stall_left = $urandom_range(1, 12);
      if (receiver_idle && stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left--;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      queue_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result status %0d data %h",
                                      rsp_tuser, rsp_tdata));
         end else begin
            want = expected_results.pop_front();
            if (rsp_tuser != want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_tuser, want.status));
            if (rsp_tdata[15:0] != want.pri)
               report_mismatch($sformatf("priority %0d, expected %0d",
                                         $signed(rsp_tdata[15:0]), want.pri));
            if (rsp_tdata[47:16] != want.pay)
               report_mismatch($sformatf("payload %h, expected %h",
                                         rsp_tdata[47:16], want.pay));
            if (rsp_tdata[50:48] != want.len)
               report_mismatch($sformatf("length %0d, expected %0d",
                                         rsp_tdata[50:48], want.len));
            if (rsp_tdata[55:51] != want.occupancy)
               report_mismatch($sformatf("occupancy %0d, expected %0d",
                                         rsp_tdata[55:51], want.occupancy));
         end
      end
   end

   task automatic test_empty_requests();
      send_request(spq_pkg::REQ_EXTRACT, 16'sd0, 32'h0, 3'd0, 16'sd0);
      send_request(spq_pkg::REQ_PEEK, 16'sh7FFF, 32'hFFFF_FFFF, 3'd7, 16'sh8000);
      send_request(spq_pkg::REQ_DELETE, 16'sd0, 32'h0, 3'd0, 16'sd0);
      send_request(spq_pkg::REQ_CHANGE, 16'sd0, 32'h0, 3'd0, 16'sd5);
      send_request(REQ_UNUSED_LO, 16'sd1, 32'h1, 3'd1, 16'sd1);
      send_request(KIND_MAX, 16'sh8000, 32'hFFFF_FFFF, 3'd4, 16'sh7FFF);
   endtask

   // Ties at both ends, saturated lengths and junk bytes, then one more when full.
   task automatic test_fill_to_full();
      send_request(spq_pkg::REQ_INSERT, 16'sh7FFF,  32'hFFFF_FFFF, 3'd4, 16'sd0);
      send_request(spq_pkg::REQ_INSERT, 16'sh8000,  32'h0000_0000, 3'd0, 16'sd0);
      send_request(spq_pkg::REQ_INSERT, 16'sd0,     32'h1234_5678, 3'd1, 16'sd0);
      send_request(spq_pkg::REQ_INSERT, 16'sd0,     32'h1234_5678, 3'd1, 16'sd0);
      send_request(spq_pkg::REQ_INSERT, -16'sd1,    32'h8000_0001, 3'd3, 16'sd0);
      send_request(spq_pkg::REQ_INSERT, 16'sd1,     32'h7FFF_FFFE, 3'd6, 16'sd0);
      send_request(spq_pkg::REQ_INSERT, 16'sh7FFF,  32'h0000_0001, 3'd4, 16'sd0);
      send_request(spq_pkg::REQ_INSERT, 16'sh8000,  32'hFFFF_FFFF, 3'd7, 16'sd0);
      send_request(spq_pkg::REQ_INSERT, 16'sd5,     32'hDEAD_1234, 3'd2, 16'sd0);
      send_request(spq_pkg::REQ_INSERT, 16'sd5,     32'h0000_BEEF, 3'd2, 16'sd0);
      send_request(spq_pkg::REQ_INSERT, 16'sd7,     32'hCAFE_F00D, 3'd5, 16'sd0);
      send_request(spq_pkg::REQ_INSERT, -16'sd100,  32'h55AA_55AA, 3'd4, 16'sd0);
      send_request(spq_pkg::REQ_INSERT, 16'sd100,   32'hAA55_AA55, 3'd3, 16'sd0);
      send_request(spq_pkg::REQ_INSERT, 16'sd7,     32'h0000_0000, 3'd0, 16'sd0);
      send_request(spq_pkg::REQ_INSERT, 16'sd2,     32'h0F0F_0F0F, 3'd4, 16'sd0);
      send_request(spq_pkg::REQ_INSERT, 16'sd3,     32'hF0F0_F0F0, 3'd1, 16'sd0);
      send_request(spq_pkg::REQ_INSERT, 16'sd9,     32'h0000_0009, 3'd4, 16'sd0);
   endtask

   task automatic test_match_rules();
      send_request(spq_pkg::REQ_PEEK, 16'sd0, 32'h0, 3'd0, 16'sd0);
      // bytes above the length must not take part in the match
      send_request(spq_pkg::REQ_DELETE, 16'sd5, 32'h5555_1234, 3'd2, 16'sd0);
      // oversized length saturates before the match
      send_request(spq_pkg::REQ_CHANGE, 16'sd7, 32'hCAFE_F00D, 3'd5, 16'sh8000);
      // one byte differs, then the length differs: both miss
      send_request(spq_pkg::REQ_DELETE, 16'sd0, 32'h1234_5679, 3'd1, 16'sd0);
      send_request(spq_pkg::REQ_DELETE, 16'sd0, 32'h1234_5678, 3'd2, 16'sd0);
      send_request(spq_pkg::REQ_EXTRACT, 16'sd0, 32'h0, 3'd0, 16'sd0);
   endtask

   task automatic test_random_traffic(input int items, input int insert_weight,
                                      input bit idle);
      sender_idle   = idle;
      receiver_idle = idle;
      repeat (items) random_request(insert_weight);
   endtask

   task automatic test_pause_until_drained();
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
      repeat (4) begin
         repeat (50) random_request(50);
         drain_results();
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = spq_pkg::REQ_INSERT;
      held_count = 0;
      error_count = 0;
      cycle_count = 0;
      full_count = 0;
      miss_count = 0;
      peak_occupancy = 0;
      stall_left = 0;
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
      foreach (kind_count[i])
         kind_count[i] = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_requests();
      test_fill_to_full();
      test_match_rules();
      test_random_traffic(400, 65, 1'b1);
      test_random_traffic(400, 30, 1'b1);
      test_pause_until_drained();
      test_random_traffic(300, 48, 1'b1);
      test_random_traffic(500, 50, 1'b0);

      drain_results();
      repeat (20) @(posedge clock);

      $display("covered: %0d insert, %0d extract, %0d peek, %0d change, %0d delete, %0d unused",
               kind_count[spq_pkg::REQ_INSERT], kind_count[spq_pkg::REQ_EXTRACT],
               kind_count[spq_pkg::REQ_PEEK], kind_count[spq_pkg::REQ_CHANGE],
               kind_count[spq_pkg::REQ_DELETE],
               kind_count[REQ_UNUSED_LO] + kind_count[REQ_UNUSED_LO + 3'd1] +
               kind_count[KIND_MAX]);
      $display("covered: %0d full refusals, %0d empty or not found, peak occupancy %0d",
               full_count, miss_count, peak_occupancy);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("%0d mismatches", error_count);
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
